/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every rising clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// check that a condition never shows up outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* rtl/core/gdnc_pkg.sv */
// ----------------------------------------------------------------------------
// Gregorian day number converter package
// Field widths, calendar constants, month table and controller/datapath types.
// ----------------------------------------------------------------------------
package gdnc_pkg;

	// field widths
	localparam int YEAR_W  = 16;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DN_W    = 25;
	localparam int TDATA_W = 56;

	// internal widths
	localparam int YI_W    = 18;            // working year, holds one step past the range
	localparam int DOY_W   = 9;             // day of year 1..366
	localparam int KY_W    = 24;
	localparam int EP_W    = DN_W + KY_W;   // year estimate product
	localparam int EP_SH   = 32;
	localparam int YEST_W  = EP_W - EP_SH;
	localparam int JC_W    = 17;            // biased year for the century quotient
	localparam int K100_W  = 18;
	localparam int JP_W    = JC_W + K100_W;
	localparam int K100_SH = 24;
	localparam int Q_W     = JP_W - K100_SH;

	// request codes
	localparam logic CMD_TO_DN   = 1'b0;
	localparam logic CMD_TO_DATE = 1'b1;

	localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTHS    = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

	// day number of January 0 of years -32768 and 32768
	localparam logic signed [DN_W-1:0] DN_LO = -25'sd12647208;
	localparam logic signed [DN_W-1:0] DN_HI = 25'sd11289324;

	// year estimate: u = n - DN_LO - 1, years = u * K_YEAR / 2^32, K_YEAR = 2^32 / 365.2425
	localparam logic [DN_W-1:0]        U_BIAS   = 25'd12647207;
	localparam logic [KY_W-1:0]        K_YEAR   = 24'd11759221;
	localparam logic signed [YI_W-1:0] YEAR_OFS = 18'sd32768;

	// century quotient: floor((y + 99) / 100) with a bias of 400 centuries
	localparam logic signed [YI_W-1:0] JC_BIAS  = 18'sd40099;
	localparam logic [K100_W-1:0]      K100     = 18'd167773;
	localparam logic signed [Q_W-1:0]  Q_BIAS   = 11'sd400;
	localparam logic [JC_W-1:0]        REM_TOP  = 17'd99;

	localparam logic signed [DN_W-1:0] JAN0_BIAS = -25'sd678942;
	localparam logic signed [DN_W:0]   YEAR_LEN  = 26'sd365;
	localparam logic [DOY_W-1:0]       DOY_MAX   = 9'd366;

	// days before the first of a month in a common year
	function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] s;
		unique case (m)
			4'd1:    s = 9'd0;
			4'd2:    s = 9'd31;
			4'd3:    s = 9'd59;
			4'd4:    s = 9'd90;
			4'd5:    s = 9'd120;
			4'd6:    s = 9'd151;
			4'd7:    s = 9'd181;
			4'd8:    s = 9'd212;
			4'd9:    s = 9'd243;
			4'd10:   s = 9'd273;
			4'd11:   s = 9'd304;
			4'd12:   s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	// controller to datapath
	typedef struct packed {
		logic load_in;   // capture the request word
		logic est;       // multiply out the year estimate
		logic yset;      // take the estimate as working year
		logic ydec;      // step year down
		logic yinc;      // step year up
		logic j1;        // January 0: century product
		logic j2;        // January 0: century quotient and remainder
		logic j3;        // January 0: sum and leap flag
		logic out_dn;    // load day number result
		logic out_date;  // load date result
		logic out_err;   // load error result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cmd;       // request code
		logic month_ok;
		logic dn_ok;
		logic j_ge;      // January 0 of working year is not before n
		logic j1_lt;     // January 0 of next year is before n
	} dp_sts_t;

endpackage

/* rtl/core/gdnc_dp.sv */
// ----------------------------------------------------------------------------
// Converter datapath
// Request registers, year estimate, January 0 evaluator, month search and
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdnc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [gdnc_pkg::TDATA_W-1:0]  s_tdata,  // year, month, day, day_number
	input  logic                          s_tuser,  // command
	input  gdnc_pkg::dp_cmd_t             cmd,
	output gdnc_pkg::dp_sts_t             sts,
	output logic [gdnc_pkg::TDATA_W-1:0]  m_tdata,  // result_day_number, result_year,
	                                                // result_month, result_day
	output logic                          m_tuser   // range_error
);
	import gdnc_pkg::*;

	logic                       cmd_q;
	logic [MONTH_W-1:0]         month_q;
	logic [DAY_W-1:0]           day_q;
	logic signed [DN_W-1:0]     dn_q;
	logic signed [YI_W-1:0]     y_q;
	logic [EP_W-1:0]            eprod_q;
	logic [JC_W-1:0]            jc_q;
	logic [JP_W-1:0]            jprod_q;
	logic signed [Q_W-1:0]      q100_q;
	logic                       rz_q;
	logic signed [DN_W-1:0]     jan_q;
	logic                       leap_q;

	logic signed [DN_W-1:0]     dn_out_q;
	logic [YEAR_W-1:0]          yr_out_q;
	logic [MONTH_W-1:0]         mo_out_q;
	logic [DAY_W-1:0]           dy_out_q;
	logic                       err_out_q;

	logic [DN_W-1:0]            u_w;
	logic [EP_W-1:0]            eprod_w;
	logic signed [YI_W-1:0]     jc_w;
	logic [JP_W-1:0]            jprod_w;
	logic [Q_W-1:0]             q_w;
	logic [JC_W-1:0]            rem_w;
	logic signed [Q_W-1:0]      q400_w;
	logic signed [YI_W-1:0]     q4_w;
	logic signed [DN_W-1:0]     y365_w;
	logic signed [DN_W-1:0]     jan_w;
	logic                       leap_w;
	logic signed [DN_W:0]       j1_w;
	logic                       adj0_w;
	logic signed [DN_W-1:0]     dn_res_w;
	logic [DN_W-1:0]            diff_w;
	logic [DOY_W-1:0]           doy_w;
	logic [MONTH_W-1:0]         mon_w;
	logic [DOY_W-1:0]           dy_full_w;

	// year estimate from the biased day number
	assign u_w     = $unsigned(dn_q) + U_BIAS;
	assign eprod_w = EP_W'(u_w) * EP_W'(K_YEAR);

	// century quotient by reciprocal multiplication
	assign jc_w    = y_q + JC_BIAS;
	assign jprod_w = JP_W'(jc_w[JC_W-1:0]) * JP_W'(K100);
	assign q_w     = jprod_q[JP_W-1 -: Q_W];
	assign rem_w   = jc_q - JC_W'(q_w) * JC_W'(7'd100);

	// January 0 of the working year and its leap flag
	assign q400_w = (q100_q + Q_W'(3)) >>> 2;
	assign q4_w   = (y_q + YI_W'(3)) >>> 2;
	assign y365_w = DN_W'(y_q) * DN_W'(365);
	assign jan_w  = y365_w + DN_W'(q4_w) - DN_W'(q100_q) + DN_W'(q400_w) + JAN0_BIAS;
	assign leap_w = (y_q[1:0] == 2'b00) && (!rz_q || (y_q[3:0] == 4'b0000));

	// January 0 of the following year
	assign j1_w = DN_W'(jan_q) + YEAR_LEN + $signed({{DN_W{1'b0}}, leap_q});

	// date to day number
	assign adj0_w   = (month_q > MONTH_FEB) && leap_q;
	assign dn_res_w = jan_q + $signed(DN_W'(month_start(month_q))) + $signed(DN_W'(day_q))
		+ $signed(DN_W'(adj0_w));

	// day of year, then the last month that starts on or before it
	assign diff_w = $unsigned(dn_q - jan_q);
	assign doy_w  = diff_w[DOY_W-1:0];

	always_comb begin
		mon_w = MONTH_MIN;
		for (int i = 2; i <= int'(MONTHS); i++) begin
			if (month_start(MONTH_W'(i)) + DOY_W'(1) + DOY_W'((i > 2) && leap_q) <= doy_w) begin
				mon_w = MONTH_W'(i);
			end
		end
	end

	assign dy_full_w = doy_w - month_start(mon_w) - DOY_W'((mon_w > MONTH_FEB) && leap_q);

	// request and working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q   <= s_tuser;
			y_q     <= YI_W'($signed(s_tdata[15:0]));
			month_q <= s_tdata[19:16];
			day_q   <= s_tdata[24:20];
			dn_q    <= $signed(s_tdata[49:25]);
		end else if (cmd.yset) begin
			y_q <= $signed({1'b0, eprod_q[EP_W-1 -: YEST_W]}) - YEAR_OFS;
		end else if (cmd.ydec) begin
			y_q <= y_q - YI_W'(1);
		end else if (cmd.yinc) begin
			y_q <= y_q + YI_W'(1);
		end
		if (cmd.est) begin
			eprod_q <= eprod_w;
		end
		if (cmd.j1) begin
			jc_q    <= jc_w[JC_W-1:0];
			jprod_q <= jprod_w;
		end
		if (cmd.j2) begin
			q100_q <= $signed(q_w) - Q_BIAS;
			rz_q   <= (rem_w == REM_TOP);
		end
		if (cmd.j3) begin
			jan_q  <= jan_w;
			leap_q <= leap_w;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_out_q  <= '0;
			yr_out_q  <= '0;
			mo_out_q  <= '0;
			dy_out_q  <= '0;
			err_out_q <= 1'b0;
		end else if (cmd.out_dn) begin
			dn_out_q  <= dn_res_w;
			yr_out_q  <= '0;
			mo_out_q  <= '0;
			dy_out_q  <= '0;
			err_out_q <= 1'b0;
		end else if (cmd.out_date) begin
			dn_out_q  <= '0;
			yr_out_q  <= y_q[YEAR_W-1:0];
			mo_out_q  <= mon_w;
			dy_out_q  <= dy_full_w[DAY_W-1:0];
			err_out_q <= 1'b0;
		end else if (cmd.out_err) begin
			dn_out_q  <= '0;
			yr_out_q  <= '0;
			mo_out_q  <= '0;
			dy_out_q  <= '0;
			err_out_q <= 1'b1;
		end
	end

	// status to the controller
	assign sts.cmd      = cmd_q;
	assign sts.month_ok = (month_q >= MONTH_MIN) && (month_q <= MONTHS);
	assign sts.dn_ok    = (dn_q > DN_LO) && (dn_q <= DN_HI);
	assign sts.j_ge     = (jan_q >= dn_q);
	assign sts.j1_lt    = (j1_w < DN_W'(dn_q));

	assign m_tdata = {{(TDATA_W - DN_W - YEAR_W - MONTH_W - DAY_W){1'b0}},
		dy_out_q, mo_out_q, yr_out_q, dn_out_q};
	assign m_tuser = err_out_q;

	`ASSERT_HOLDS(a_doy_range, clk, arst_n, cmd.out_date |-> (doy_w >= DOY_W'(1) && doy_w <= DOY_MAX))
	`ASSERT_HOLDS(a_year_found, clk, arst_n, cmd.out_date |-> (!sts.j_ge && !sts.j1_lt))
	`ASSERT_HOLDS(a_month_valid, clk, arst_n, cmd.out_date |=> (mo_out_q >= MONTH_MIN && mo_out_q <= MONTHS))
	`ASSERT_HOLDS(a_err_clears, clk, arst_n, err_out_q |-> (dn_out_q == '0 && yr_out_q == '0 && mo_out_q == '0 && dy_out_q == '0))

endmodule

/* rtl/core/gdnc_ctrl.sv */
// ----------------------------------------------------------------------------
// Converter controller
// Sequences one request through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdnc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  gdnc_pkg::dp_sts_t   sts,
	output gdnc_pkg::dp_cmd_t   cmd
);
	import gdnc_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_EST  = 8'b0000_0010,
		ST_YSET = 8'b0000_0100,
		ST_J1   = 8'b0000_1000,
		ST_J2   = 8'b0001_0000,
		ST_J3   = 8'b0010_0000,
		ST_ADJ  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   err_q, err_d;
	logic   out_valid_q;
	logic   out_free;
	logic   out_load;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_load = cmd.out_dn || cmd.out_date || cmd.out_err;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		err_d   = err_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					err_d       = 1'b0;
					state_d     = ST_EST;
				end
			end
			ST_EST: begin
				if (sts.cmd == CMD_TO_DN) begin
					if (sts.month_ok) begin
						state_d = ST_J1;
					end else begin
						err_d   = 1'b1;
						state_d = ST_FIN;
					end
				end else if (sts.dn_ok) begin
					cmd.est = 1'b1;
					state_d = ST_YSET;
				end else begin
					err_d   = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_YSET: begin
				cmd.yset = 1'b1;
				state_d  = ST_J1;
			end
			ST_J1: begin
				cmd.j1  = 1'b1;
				state_d = ST_J2;
			end
			ST_J2: begin
				cmd.j2  = 1'b1;
				state_d = ST_J3;
			end
			ST_J3: begin
				cmd.j3  = 1'b1;
				state_d = (sts.cmd == CMD_TO_DATE) ? ST_ADJ : ST_FIN;
			end
			ST_ADJ: begin
				// step the year until n falls inside it
				priority if (sts.j_ge) begin
					cmd.ydec = 1'b1;
					state_d  = ST_J1;
				end else if (sts.j1_lt) begin
					cmd.yinc = 1'b1;
					state_d  = ST_J1;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold until the result register frees up
				if (out_free) begin
					priority if (err_q) begin
						cmd.out_err = 1'b1;
					end else if (sts.cmd == CMD_TO_DATE) begin
						cmd.out_date = 1'b1;
					end else begin
						cmd.out_dn = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, error flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_HOLDS(a_out_free, clk, arst_n, out_load |-> (!out_valid_q || m_tready))
	`ASSERT_HOLDS(a_busy_after_accept, clk, arst_n, (s_tvalid && s_tready) |=> (state_q != ST_IDLE))
	`ASSERT_HOLDS(a_jan0_seq, clk, arst_n, (state_q == ST_J1) |=> (state_q == ST_J2) ##1 (state_q == ST_J3))

endmodule

/* rtl/core/gregorian_day_number_converter.sv */
// ----------------------------------------------------------------------------
// Gregorian day number converter
// Converts a proleptic Gregorian date to a Modified Julian Day number
// (command 0) or back (command 1), one request at a time. A request is taken
// only while the converter is idle. Its result then sits in an output
// register, so the next request can be taken while that word waits. A date
// to day number request passes the month check and the January 0 evaluator
// before its result loads. A day number to date request first multiplies out
// the year estimate and takes it as the working year, then runs the evaluator
// once more for each step that corrects the year estimate (usually none, at
// most two). A bad month, or a day number whose year lies outside
// -32768..32767, returns with range_error set and all other fields zero. The
// next request can be accepted in the cycle after the result loads, even while
// that word still waits in the output register. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module gregorian_day_number_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [gdnc_pkg::TDATA_W-1:0]  s_tdata,   // year[15:0], month[19:16], day[24:20],
	                                                 // day_number[49:25]
	input  logic                          s_tuser,   // command
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [gdnc_pkg::TDATA_W-1:0]  m_tdata,   // result_day_number[24:0],
	                                                 // result_year[40:25],
	                                                 // result_month[44:41],
	                                                 // result_day[49:45]
	output logic                          m_tuser    // range_error
);
	import gdnc_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// sequence the request
	gdnc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	// do the arithmetic and hold the result word
	gdnc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (dp_cmd),
		.sts     (dp_sts),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

/* tb/gregorian_day_number_converter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian day number converter testbench
// Drives date and day number requests through the slave stream, with bursty
// input and a receiver that stalls in several patterns. Expected words are
// worked out by a calendar predictor, or typed in for the obvious rows of the
// directed table, and each returned word is compared field by field.
// ----------------------------------------------------------------------------
module gregorian_day_number_converter_tb;
	import gdnc_pkg::*;

	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 24;

	typedef struct packed {
		logic                     cmd;
		logic signed [YEAR_W-1:0] year;
		logic [MONTH_W-1:0]       month;
		logic [DAY_W-1:0]         day;
		logic signed [DN_W-1:0]   day_number;
	} calendar_req_t;

	typedef struct packed {
		logic signed [DN_W-1:0]   dn;
		logic signed [YEAR_W-1:0] year;
		logic [MONTH_W-1:0]       month;
		logic [DAY_W-1:0]         day;
		logic                     err;
	} calendar_res_t;

	typedef struct packed {
		calendar_req_t req;
		logic          typed;
		calendar_res_t want;
	} directed_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_LONG} rx_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tuser;

	calendar_res_t pending_results[$];
	directed_row_t directed_rows[$];

	int errors = 0;
	int cycles = 0;
	int words_checked = 0;
	int to_dn_sent = 0;
	int to_date_sent = 0;
	int range_errors_seen = 0;
	int burst_left = 0;

	gregorian_day_number_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// calendar predictor
	// ------------------------------------------------------------------

	// floor division by a positive divisor
	function automatic longint floor_quot(longint a, longint d);
		longint q;
		q = a / d;
		if ((a % d) < 0)
			q--;
		return q;
	endfunction

	// day number of December 31 of the year before
	function automatic longint jan_zero(longint y);
		longint s;
		s = y + 99999999;
		return y * 365 + floor_quot(s, 4) - floor_quot(s, 100) + floor_quot(s, 400) - 24928941;
	endfunction

	// day number of day 0 of month m (1..13) in year y
	function automatic longint month_base(longint y, int m);
		longint r;
		int     skew;
		case (m)
			1:       skew = 0;
			2:       skew = 2;
			3:       skew = 1;
			4:       skew = 3;
			5:       skew = 4;
			6:       skew = 6;
			7:       skew = 7;
			8:       skew = 9;
			9:       skew = 11;
			10:      skew = 12;
			11:      skew = 14;
			12:      skew = 15;
			default: skew = 17;
		endcase
		r = jan_zero(y) + longint'((m - 1) * 29 + skew);
		if (m > 2 && (jan_zero(y + 1) - jan_zero(y)) == 366)
			r++;
		return r;
	endfunction

	function automatic calendar_res_t convert_calendar(calendar_req_t r);
		calendar_res_t o;
		longint        n, y, j;
		int            m;
		o = '0;
		if (r.cmd == CMD_TO_DN) begin
			if (r.month < MONTH_MIN || r.month > MONTHS)
				o.err = 1'b1;
			else
				o.dn = month_base(longint'(r.year), int'(r.month)) + longint'(r.day);
		end else begin
			n = longint'(r.day_number);
			y = floor_quot((n + 2400000 - 1721058) * 400, 146097) + 1;
			while (jan_zero(y) >= n)
				y--;
			while (jan_zero(y + 1) < n)
				y++;
			if (y < -32768 || y > 32767) begin
				o.err = 1'b1;
			end else begin
				j = jan_zero(y);
				m = int'((n - j) / 29) + 1;
				if (m > 13)
					m = 13;
				while (m > 1 && month_base(y, m) + 1 > n)
					m--;
				o.year  = y;
				o.month = m;
				o.day   = n - month_base(y, m);
			end
		end
		return o;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic calendar_req_t make_req(logic cmd, logic signed [YEAR_W-1:0] yr,
			logic [MONTH_W-1:0] mo, logic [DAY_W-1:0] dy, logic signed [DN_W-1:0] dn);
		calendar_req_t r;
		r.cmd        = cmd;
		r.year       = yr;
		r.month      = mo;
		r.day        = dy;
		r.day_number = dn;
		return r;
	endfunction

	function automatic calendar_res_t make_res(logic signed [DN_W-1:0] dn,
			logic signed [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo, logic [DAY_W-1:0] dy,
			logic err);
		calendar_res_t o;
		o.dn    = dn;
		o.year  = yr;
		o.month = mo;
		o.day   = dy;
		o.err   = err;
		return o;
	endfunction

	function automatic void add_typed(calendar_req_t r, calendar_res_t want);
		directed_rows.push_back('{req: r, typed: 1'b1, want: want});
	endfunction

	function automatic void add_predicted(calendar_req_t r);
		directed_rows.push_back('{req: r, typed: 1'b0, want: '0});
	endfunction

	task automatic flag_error(string msg);
		$display("ERROR cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// present one word and hold it until taken; returns at the next falling edge
	task automatic send_word(calendar_req_t r, calendar_res_t want);
		s_tvalid <= 1'b1;
		s_tuser  <= r.cmd;
		s_tdata  <= {{(TDATA_W - 50){1'b0}}, r.day_number, r.day, r.month, r.year};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(want);
		if (r.cmd == CMD_TO_DN)
			to_dn_sent++;
		else
			to_date_sent++;
		if (want.err)
			range_errors_seen++;
		@(negedge clk);
	endtask

	// insert a random gap between bursts of back-to-back words
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
	endtask

	// drop valid and hold off until every expected word has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	function automatic calendar_req_t random_request();
		calendar_req_t r;
		longint        n, y;
		int            pick;
		r = make_req($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			// month in 1..12, year near the present, at the extremes or random
			r.cmd = CMD_TO_DN;
			case ($urandom_range(0, 3))
				0:       r.year = $urandom_range(0, 4000) - 2000;
				1:       r.year = (($urandom_range(0, 1) == 1) ? 32767 : -32768)
				                  - $urandom_range(0, 3) * (($urandom_range(0, 1) == 1) ? 1 : -1);
				default: r.year = $urandom;
			endcase
			r.month = $urandom_range(1, 12);
			r.day   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 28);
		end else if (pick < 46) begin
			// month outside 1..12
			r.cmd   = CMD_TO_DN;
			r.month = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
		end else if (pick < 76) begin
			// day number inside the supported years
			r.cmd = CMD_TO_DATE;
			n = longint'(DN_LO) + 1 + $urandom_range(int'(DN_HI) - int'(DN_LO) - 1);
			r.day_number = n;
		end else if (pick < 90) begin
			// day number just around a new year
			r.cmd = CMD_TO_DATE;
			y = longint'($signed(16'($urandom)));
			if ($urandom_range(0, 1) == 1)
				y = y + 1;
			n = jan_zero(y) + $urandom_range(0, 3) - 1;
			r.day_number = n;
		end else begin
			// any 25-bit day number, in range or out of range
			r.cmd = CMD_TO_DATE;
			r.day_number = $urandom;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// receiver: stall pattern is picked at random and kept for a random run of cycles
	// ------------------------------------------------------------------
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 80);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
			RX_SPARSE: m_tready <= (rx_left % 5 == 0);
			default:   m_tready <= (rx_left % 24 >= 18);
		endcase
	end

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		calendar_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.dn    = m_tdata[24:0];
			got.year  = m_tdata[40:25];
			got.month = m_tdata[44:41];
			got.day   = m_tdata[49:45];
			got.err   = m_tuser;
			if (pending_results.size() == 0) begin
				flag_error("result word with no request pending");
			end else begin
				want = pending_results.pop_front();
				if (got.dn !== want.dn)
					flag_error($sformatf("word %0d day number %0d, want %0d",
						words_checked, got.dn, want.dn));
				if (got.year !== want.year)
					flag_error($sformatf("word %0d year %0d, want %0d",
						words_checked, got.year, want.year));
				if (got.month !== want.month)
					flag_error($sformatf("word %0d month %0d, want %0d",
						words_checked, got.month, want.month));
				if (got.day !== want.day)
					flag_error($sformatf("word %0d day %0d, want %0d",
						words_checked, got.day, want.day));
				if (got.err !== want.err)
					flag_error($sformatf("word %0d range error %0b, want %0b",
						words_checked, got.err, want.err));
			end
			words_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycles, pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : main_sequence
		calendar_req_t r;
		calendar_res_t want;

		// directed table
		add_typed(make_req(CMD_TO_DN, 1858, 11, 17, 0), make_res(0, 0, 0, 0, 1'b0));
		add_typed(make_req(CMD_TO_DATE, 0, 0, 0, 0), make_res(0, 1858, 11, 17, 1'b0));
		add_typed(make_req(CMD_TO_DN, 2000, 0, 1, 0), make_res(0, 0, 0, 0, 1'b1));
		add_typed(make_req(CMD_TO_DN, 2000, 13, 1, 0), make_res(0, 0, 0, 0, 1'b1));
		add_typed(make_req(CMD_TO_DN, -1, 15, 31, -1), make_res(0, 0, 0, 0, 1'b1));
		add_typed(make_req(CMD_TO_DATE, 0, 0, 0, -16777216), make_res(0, 0, 0, 0, 1'b1));
		add_typed(make_req(CMD_TO_DATE, -1, 15, 31, 16777215), make_res(0, 0, 0, 0, 1'b1));
		add_predicted(make_req(CMD_TO_DN, -32768, 1, 0, 0));
		add_predicted(make_req(CMD_TO_DN, 32767, 12, 31, 0));
		add_predicted(make_req(CMD_TO_DN, 2000, 2, 29, 0));
		add_predicted(make_req(CMD_TO_DN, 2000, 3, 1, 0));
		add_predicted(make_req(CMD_TO_DN, 1900, 3, 1, 0));
		add_predicted(make_req(CMD_TO_DN, 2023, 2, 31, 0));
		add_predicted(make_req(CMD_TO_DN, 2023, 3, 0, 0));
		add_predicted(make_req(CMD_TO_DN, 0, 3, 1, 0));
		add_predicted(make_req(CMD_TO_DN, -1, 12, 31, 0));
		add_predicted(make_req(CMD_TO_DATE, 0, 0, 0, DN_LO));
		add_predicted(make_req(CMD_TO_DATE, 0, 0, 0, DN_LO + 1));
		add_predicted(make_req(CMD_TO_DATE, 0, 0, 0, DN_HI));
		add_predicted(make_req(CMD_TO_DATE, 0, 0, 0, DN_HI + 1));
		add_predicted(make_req(CMD_TO_DATE, 0, 0, 0, 51603));
		add_predicted(make_req(CMD_TO_DATE, 0, 0, 0, 51604));
		add_predicted(make_req(CMD_TO_DATE, 0, 0, 0, 51909));
		add_predicted(make_req(CMD_TO_DATE, 0, 0, 0, 51910));
		add_predicted(make_req(CMD_TO_DATE, 0, 0, 0, -1));

		// hold reset, then release it on a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			pace_sender();
			want = directed_rows[i].typed ? directed_rows[i].want
			                              : convert_calendar(directed_rows[i].req);
			send_word(directed_rows[i].req, want);
		end
		wait_drained();

		// random requests, draining the converter every 300 words
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 300 == 299)
				wait_drained();
			pace_sender();
			r = random_request();
			send_word(r, convert_calendar(r));
		end

		// let the last words come back, then check that none is still expected
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_results.size() != 0)
			flag_error($sformatf("%0d expected words never arrived", pending_results.size()));

		$display("covered %0d date to day number and %0d day number to date requests",
			to_dn_sent, to_date_sent);
		$display("%0d words checked, %0d of them with range error, %0d mismatches",
			words_checked, range_errors_seen, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
